FILE: hdl/spism_pkg.sv
// ----------------------------------------------------------------------------
// spism_pkg
// Types, register indexes and the transaction step table shared by the SPI
// EEPROM/sensor master front end, engine and top level.
// ----------------------------------------------------------------------------
package spism_pkg;

	// action codes on the input side
	localparam logic [2:0] ACT_TICK   = 3'd0;
	localparam logic [2:0] ACT_EE_RD  = 3'd1;
	localparam logic [2:0] ACT_EE_WR  = 3'd2;
	localparam logic [2:0] ACT_SEN_RD = 3'd3;
	localparam logic [2:0] ACT_SEN_WR = 3'd4;

	// configuration register indexes
	localparam logic [2:0] REG_READ_OPCODE     = 3'd0;
	localparam logic [2:0] REG_WRITE_OPCODE    = 3'd1;
	localparam logic [2:0] REG_WREN_OPCODE     = 3'd2;
	localparam logic [2:0] REG_ENABLE_GAP      = 3'd3;
	localparam logic [2:0] REG_SEN_RD_ADDR_WT  = 3'd4;
	localparam logic [2:0] REG_SEN_RD_HOLD     = 3'd5;
	localparam logic [2:0] REG_SEN_WR_ADDR_WT  = 3'd6;
	localparam logic [2:0] REG_SEN_WR_HOLD     = 3'd7;

	// pin order in the pin vector
	localparam int PIN_SCLK = 0;
	localparam int PIN_MOSI = 1;
	localparam int PIN_EE   = 2;
	localparam int PIN_SEN  = 3;

	localparam logic [3:0] PINS_IDLE   = 4'b1111;
	localparam logic [3:0] PINS_EE_SEL = 4'b1011;
	localparam logic [3:0] PINS_SEN_SEL = 4'b0111;
	localparam logic [3:0] BITS_PER_BYTE = 4'd8;
	localparam logic [3:0] PHASE_IDLE  = 4'd0;
	localparam logic [3:0] PHASE_FIRST = 4'd1;

	typedef enum logic [1:0] {
		CL_TICK = 2'd0,
		CL_CMD  = 2'd1,
		CL_NOP  = 2'd2
	} item_class_t;

	typedef enum logic [2:0] {
		K_BYTE   = 3'd0,
		K_WAIT   = 3'd1,
		K_DESEL  = 3'd2,
		K_SEL    = 3'd3,
		K_FINISH = 3'd4
	} step_kind_t;

	typedef struct packed {
		item_class_t cls;
		logic [2:0]  action;
		logic [8:0]  address;
		logic [7:0]  wr_data;
		logic        miso;
	} item_t;

	typedef struct packed {
		logic       sclk;
		logic       mosi;
		logic       eeprom_select_n;
		logic       sensor_select_n;
		logic       busy_res;
		logic       read_valid;
		logic [7:0] read_byte;
		logic       rejected;
	} result_t;

	typedef struct packed {
		logic [7:0]  read_opcode;
		logic [7:0]  write_opcode;
		logic [7:0]  write_enable_opcode;
		logic [15:0] enable_gap_ticks;
		logic [15:0] sensor_read_addr_wait;
		logic [15:0] sensor_read_hold;
		logic [15:0] sensor_write_addr_wait;
		logic [15:0] sensor_write_hold;
	} cfg_t;

	typedef struct packed {
		step_kind_t  kind;
		logic [15:0] val;
	} step_t;

	// what a transaction does at a given phase, with its byte or wait count
	function automatic step_t step_of(logic [2:0] act, logic [3:0] ph, logic [8:0] addr,
			logic [7:0] data, cfg_t cfg);
		step_t      s;
		logic [7:0] a8;
		logic [7:0] rg;
		s.kind = K_FINISH;
		s.val  = '0;
		a8     = {4'b0000, addr[8], 3'b000};
		rg     = {1'b0, addr[6:0]};
		case (act)
			ACT_EE_RD: begin
				case (ph)
					4'd1: s = '{kind: K_BYTE, val: {8'h00, cfg.read_opcode | a8}};
					4'd2: s = '{kind: K_BYTE, val: {8'h00, addr[7:0]}};
					4'd3: s = '{kind: K_BYTE, val: 16'h00ff};
					default: s = '{kind: K_FINISH, val: 16'h0000};
				endcase
			end
			ACT_EE_WR: begin
				case (ph)
					4'd1: s = '{kind: K_BYTE, val: {8'h00, cfg.write_enable_opcode}};
					4'd2: s = '{kind: K_DESEL, val: 16'h0000};
					4'd3: s = '{kind: K_WAIT, val: cfg.enable_gap_ticks};
					4'd4: s = '{kind: K_SEL, val: 16'h0000};
					4'd5: s = '{kind: K_BYTE, val: {8'h00, cfg.write_opcode | a8}};
					4'd6: s = '{kind: K_BYTE, val: {8'h00, addr[7:0]}};
					4'd7: s = '{kind: K_BYTE, val: {8'h00, data}};
					default: s = '{kind: K_FINISH, val: 16'h0000};
				endcase
			end
			ACT_SEN_RD: begin
				case (ph)
					4'd1: s = '{kind: K_BYTE, val: {8'h00, rg}};
					4'd2: s = '{kind: K_WAIT, val: cfg.sensor_read_addr_wait};
					4'd3: s = '{kind: K_BYTE, val: 16'h00ff};
					4'd4: s = '{kind: K_WAIT, val: cfg.sensor_read_hold};
					default: s = '{kind: K_FINISH, val: 16'h0000};
				endcase
			end
			ACT_SEN_WR: begin
				case (ph)
					4'd1: s = '{kind: K_BYTE, val: {8'h00, rg | 8'h80}};
					4'd2: s = '{kind: K_WAIT, val: cfg.sensor_write_addr_wait};
					4'd3: s = '{kind: K_BYTE, val: {8'h00, data}};
					4'd4: s = '{kind: K_WAIT, val: cfg.sensor_write_hold};
					default: s = '{kind: K_FINISH, val: 16'h0000};
				endcase
			end
			default: s = '{kind: K_FINISH, val: 16'h0000};
		endcase
		return s;
	endfunction

endpackage

FILE: hdl/spism_front.sv
// ----------------------------------------------------------------------------
// spism_front
// Input side: classifies each word as tick, command or no-op and holds it in
// a two-entry queue until the engine takes it.
// ----------------------------------------------------------------------------
module spism_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [2:0]       action,
	input  logic [8:0]       address,
	input  logic [7:0]       wr_data,
	input  logic             miso,
	output logic             item_valid,
	output spism_pkg::item_t item,
	input  logic             item_pop
);
	import spism_pkg::*;

	item_t       entry_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	item_t       in_item;
	logic        do_push;

	always_comb begin
		in_item.action     = action;
		in_item.address    = address;
		in_item.wr_data    = wr_data;
		in_item.miso       = miso;
		if (action == ACT_TICK) begin
			in_item.cls = CL_TICK;
		end else if (action inside {[ACT_EE_RD:ACT_SEN_WR]}) begin
			in_item.cls = CL_CMD;
		end else begin
			in_item.cls = CL_NOP;
		end
	end

	assign full       = (count_q == 2'd2);
	assign do_push    = push && !full;
	assign item_valid = (count_q != 2'd0);
	assign item       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (item_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, do_push} - {1'b0, item_pop};
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'd2)
		else $error("front queue count out of range");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		item_pop |-> count_q != 2'd0)
		else $error("engine took a word from an empty front queue");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !item_pop) |=> count_q == $past(count_q) + 2'd1)
		else $error("front queue lost a word");

endmodule

FILE: hdl/spism_back.sv
// ----------------------------------------------------------------------------
// spism_back
// Serial engine: runs one word per cycle, while the result queue has room,
// against the sequencer and pins, and queues resulting pin levels and status.
// ----------------------------------------------------------------------------
module spism_back (
	input  logic               clk,
	input  logic               arst_n,
	input  spism_pkg::cfg_t    cfg,
	input  logic               item_valid,
	input  spism_pkg::item_t   item,
	output logic               item_pop,
	output logic               empty,
	input  logic               pop,
	output spism_pkg::result_t result
);
	import spism_pkg::*;

	// sequencer and shifter state
	logic [3:0]  phase_q;
	logic [2:0]  act_q;
	logic [8:0]  addr_q;
	logic [7:0]  data_q;
	logic [7:0]  shreg_q;
	logic [3:0]  bc_q;
	logic        half_q;
	logic [15:0] wait_q;
	logic [3:0]  pins_q;

	logic [3:0]  phase_d;
	logic [2:0]  act_d;
	logic [8:0]  addr_d;
	logic [7:0]  data_d;
	logic [7:0]  shreg_d;
	logic [3:0]  bc_d;
	logic        half_d;
	logic [15:0] wait_d;
	logic [3:0]  pins_d;

	step_t       st0;
	step_t       st_e;
	step_t       st_n;
	step_t       st_c;
	logic        expired;
	logic [3:0]  ph_e;
	logic [3:0]  ph_n;
	logic [7:0]  sh_e;
	logic        half_e;
	logic [3:0]  bc_e;
	logic [3:0]  bc_inc;
	logic        do_enter;
	logic        rd_done;
	logic        rej;
	result_t     res;

	// result queue
	result_t     out_q [2];
	logic        owr_ptr_q;
	logic        ord_ptr_q;
	logic [1:0]  ocount_q;
	logic        out_full;
	logic        out_pop;

	assign out_full = (ocount_q == 2'd2);
	assign item_pop = item_valid && !out_full;
	assign empty    = (ocount_q == 2'd0);
	assign out_pop  = pop && !empty;
	assign result   = out_q[ord_ptr_q];

	always_comb begin
		// a wait that has run out falls through to the next step on this tick
		st0     = step_of(act_q, phase_q, addr_q, data_q, cfg);
		expired = (st0.kind == K_WAIT) && (wait_q == 16'd0);
		ph_e    = expired ? phase_q + 4'd1 : phase_q;
		st_e    = step_of(act_q, ph_e, addr_q, data_q, cfg);
		sh_e    = expired ? st_e.val[7:0] : shreg_q;
		half_e  = expired ? 1'b0 : half_q;
		bc_e    = expired ? 4'd0 : bc_q;
		bc_inc  = bc_e + 4'd1;
		ph_n    = ph_e + 4'd1;
		st_n    = step_of(act_q, ph_n, addr_q, data_q, cfg);
		st_c    = step_of(item.action, PHASE_FIRST, item.address, item.wr_data, cfg);

		phase_d  = phase_q;
		act_d    = act_q;
		addr_d   = addr_q;
		data_d   = data_q;
		shreg_d  = shreg_q;
		bc_d     = bc_q;
		half_d   = half_q;
		wait_d   = wait_q;
		pins_d   = pins_q;
		do_enter = 1'b0;
		rd_done  = 1'b0;
		rej      = 1'b0;

		if (item_pop) begin
			case (item.cls)
				CL_TICK: begin
					if (phase_q != PHASE_IDLE) begin
						case (st_e.kind)
							K_BYTE: begin
								phase_d = ph_e;
								if (!half_e) begin
									pins_d[PIN_SCLK] = 1'b0;
									pins_d[PIN_MOSI] = sh_e[7];
									half_d  = 1'b1;
									shreg_d = sh_e;
									bc_d    = bc_e;
								end else begin
									pins_d[PIN_SCLK] = 1'b1;
									shreg_d  = {sh_e[6:0], item.miso};
									bc_d     = bc_inc;
									half_d   = 1'b0;
									do_enter = (bc_inc >= BITS_PER_BYTE);
								end
							end
							K_WAIT: begin
								wait_d = wait_q - 16'd1;
							end
							K_DESEL: begin
								pins_d[PIN_EE]   = 1'b1;
								pins_d[PIN_MOSI] = 1'b1;
								pins_d[PIN_SCLK] = 1'b1;
								do_enter = 1'b1;
							end
							K_SEL: begin
								pins_d[PIN_EE] = 1'b0;
								do_enter = 1'b1;
							end
							K_FINISH: begin
								pins_d  = PINS_IDLE;
								phase_d = PHASE_IDLE;
								rd_done = (act_q == ACT_EE_RD) || (act_q == ACT_SEN_RD);
							end
							default: ;
						endcase
						// advance to the next step and load its byte or count
						if (do_enter) begin
							phase_d = ph_n;
							if (st_n.kind == K_BYTE) begin
								shreg_d = st_n.val[7:0];
								bc_d    = 4'd0;
								half_d  = 1'b0;
							end else if (st_n.kind == K_WAIT) begin
								wait_d = st_n.val;
							end
						end
					end
				end
				CL_CMD: begin
					if (phase_q != PHASE_IDLE) begin
						rej = 1'b1;
					end else begin
						act_d   = item.action;
						addr_d  = item.address;
						data_d  = item.wr_data;
						pins_d  = (item.action <= ACT_EE_WR) ? PINS_EE_SEL : PINS_SEN_SEL;
						phase_d = PHASE_FIRST;
						shreg_d = st_c.val[7:0];
						bc_d    = 4'd0;
						half_d  = 1'b0;
					end
				end
				default: ;
			endcase
		end

		res.sclk            = pins_d[PIN_SCLK];
		res.mosi            = pins_d[PIN_MOSI];
		res.eeprom_select_n = pins_d[PIN_EE];
		res.sensor_select_n = pins_d[PIN_SEN];
		res.busy_res        = (phase_d != PHASE_IDLE);
		res.read_valid      = rd_done;
		res.read_byte       = rd_done ? shreg_d : 8'h00;
		res.rejected        = rej;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PHASE_IDLE;
			act_q   <= '0;
			addr_q  <= '0;
			data_q  <= '0;
			shreg_q <= '0;
			bc_q    <= '0;
			half_q  <= 1'b0;
			wait_q  <= '0;
			pins_q  <= PINS_IDLE;
		end else if (item_pop) begin
			phase_q <= phase_d;
			act_q   <= act_d;
			addr_q  <= addr_d;
			data_q  <= data_d;
			shreg_q <= shreg_d;
			bc_q    <= bc_d;
			half_q  <= half_d;
			wait_q  <= wait_d;
			pins_q  <= pins_d;
		end
	end

	always_ff @(posedge clk) begin
		if (item_pop) begin
			out_q[owr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_ptr_q <= 1'b0;
			ord_ptr_q <= 1'b0;
			ocount_q  <= 2'd0;
		end else begin
			if (item_pop) begin
				owr_ptr_q <= !owr_ptr_q;
			end
			if (out_pop) begin
				ord_ptr_q <= !ord_ptr_q;
			end
			ocount_q <= ocount_q + {1'b0, item_pop} - {1'b0, out_pop};
		end
	end

	a_idle_pins: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PHASE_IDLE |-> pins_q == PINS_IDLE)
		else $error("pins not idle while no transaction runs");

	a_one_select: assert property (@(posedge clk) disable iff (!arst_n)
		!(!pins_q[PIN_EE] && !pins_q[PIN_SEN]))
		else $error("both chip selects active");

	a_half_sclk_low: assert property (@(posedge clk) disable iff (!arst_n)
		half_q |-> !pins_q[PIN_SCLK])
		else $error("mid-bit with sclk high");

	a_bit_count: assert property (@(posedge clk) disable iff (!arst_n)
		bc_q <= BITS_PER_BYTE)
		else $error("bit count past one byte");

	a_out_count: assert property (@(posedge clk) disable iff (!arst_n)
		ocount_q <= 2'd2)
		else $error("result queue overflow");

endmodule

FILE: hdl/spi_eeprom_and_sensor_master.sv
// ----------------------------------------------------------------------------
// spi_eeprom_and_sensor_master
// SPI mode-3 master for an EEPROM and a register-mapped sensor on separate
// selects; one word is a command or a half-period tick with the MISO sample.
// ----------------------------------------------------------------------------
// A result is registered into the result queue when its word is taken.
// Throughput: one word per cycle while the result queue is not full.
// Front and result queues hold two words each; full rises when the front queue holds two.
// Reset: queues empty, pins high, sequencer idle, registers to default values.
module spi_eeprom_and_sensor_master (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  action,
	input  logic [8:0]  address,
	input  logic [7:0]  wr_data,
	input  logic        miso,
	output logic        empty,
	input  logic        pop,
	output logic        sclk,
	output logic        mosi,
	output logic        eeprom_select_n,
	output logic        sensor_select_n,
	output logic        busy_res,
	output logic        read_valid,
	output logic [7:0]  read_byte,
	output logic        rejected,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import spism_pkg::*;

	cfg_t    cfg_q;
	item_t   item;
	logic    item_valid;
	logic    item_pop;
	result_t result;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.read_opcode            <= 8'd3;
			cfg_q.write_opcode           <= 8'd2;
			cfg_q.write_enable_opcode    <= 8'd6;
			cfg_q.enable_gap_ticks       <= 16'd300;
			cfg_q.sensor_read_addr_wait  <= 16'd100;
			cfg_q.sensor_read_hold       <= 16'd120;
			cfg_q.sensor_write_addr_wait <= 16'd50;
			cfg_q.sensor_write_hold      <= 16'd30;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_READ_OPCODE:    cfg_q.read_opcode            <= cfg_data[7:0];
				REG_WRITE_OPCODE:   cfg_q.write_opcode           <= cfg_data[7:0];
				REG_WREN_OPCODE:    cfg_q.write_enable_opcode    <= cfg_data[7:0];
				REG_ENABLE_GAP:     cfg_q.enable_gap_ticks       <= cfg_data;
				REG_SEN_RD_ADDR_WT: cfg_q.sensor_read_addr_wait  <= cfg_data;
				REG_SEN_RD_HOLD:    cfg_q.sensor_read_hold       <= cfg_data;
				REG_SEN_WR_ADDR_WT: cfg_q.sensor_write_addr_wait <= cfg_data;
				REG_SEN_WR_HOLD:    cfg_q.sensor_write_hold      <= cfg_data;
				default: ;
			endcase
		end
	end

	spism_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.action     (action),
		.address    (address),
		.wr_data    (wr_data),
		.miso       (miso),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop)
	);

	spism_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop),
		.empty      (empty),
		.pop        (pop),
		.result     (result)
	);

	assign sclk            = result.sclk;
	assign mosi            = result.mosi;
	assign eeprom_select_n = result.eeprom_select_n;
	assign sensor_select_n = result.sensor_select_n;
	assign busy_res        = result.busy_res;
	assign read_valid      = result.read_valid;
	assign read_byte       = result.read_byte;
	assign rejected        = result.rejected;

endmodule

FILE: sim/spi_link_checker.sv
// ----------------------------------------------------------------------------
// spi_link_checker
// Watches the word, result and register channels of the SPI EEPROM/sensor
// master, steps its own model of the serial sequencer on every word taken,
// and compares each result word popped against the oldest forecast.
// ----------------------------------------------------------------------------
module spi_link_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [2:0]  action,
	input  logic [8:0]  address,
	input  logic [7:0]  wr_data,
	input  logic        miso,
	input  logic        empty,
	input  logic        pop,
	input  logic        sclk,
	input  logic        mosi,
	input  logic        eeprom_select_n,
	input  logic        sensor_select_n,
	input  logic        busy_res,
	input  logic        read_valid,
	input  logic [7:0]  read_byte,
	input  logic        rejected,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          errors,
	output int          pending,
	output logic        link_busy
);
	timeunit 1ns;
	timeprecision 1ps;
	import spism_pkg::*;

	localparam int SHOW_LIMIT = 10;

	cfg_t       cfg;
	logic [3:0] ph;
	logic [2:0] cur;
	logic [8:0] haddr;
	logic [7:0] hdata;
	logic [7:0] shreg;
	logic [3:0] nbits;
	logic       half;
	logic [15:0] wcnt;
	logic [3:0] pins;

	result_t due_states[$];
	int      bad;

	function automatic void clear_link();
		cfg = '{read_opcode: 8'd3, write_opcode: 8'd2, write_enable_opcode: 8'd6,
			enable_gap_ticks: 16'd300, sensor_read_addr_wait: 16'd100,
			sensor_read_hold: 16'd120, sensor_write_addr_wait: 16'd50,
			sensor_write_hold: 16'd30};
		ph    = PHASE_IDLE;
		cur   = ACT_TICK;
		haddr = '0;
		hdata = '0;
		shreg = '0;
		nbits = '0;
		half  = 1'b0;
		wcnt  = '0;
		pins  = PINS_IDLE;
	endfunction

	// what the running transaction does in its current phase
	function automatic step_kind_t phase_step(output logic [15:0] val);
		logic [7:0] a8;
		logic [7:0] rg;
		a8  = haddr[8] ? 8'h08 : 8'h00;
		rg  = {1'b0, haddr[6:0]};
		val = '0;
		case (cur)
			ACT_EE_RD: begin
				if (ph == 4'd1) begin val = {8'h00, cfg.read_opcode | a8}; return K_BYTE; end
				if (ph == 4'd2) begin val = {8'h00, haddr[7:0]}; return K_BYTE; end
				if (ph == 4'd3) begin val = 16'h00ff; return K_BYTE; end
			end
			ACT_EE_WR: begin
				if (ph == 4'd1) begin val = {8'h00, cfg.write_enable_opcode}; return K_BYTE; end
				if (ph == 4'd2) return K_DESEL;
				if (ph == 4'd3) begin val = cfg.enable_gap_ticks; return K_WAIT; end
				if (ph == 4'd4) return K_SEL;
				if (ph == 4'd5) begin val = {8'h00, cfg.write_opcode | a8}; return K_BYTE; end
				if (ph == 4'd6) begin val = {8'h00, haddr[7:0]}; return K_BYTE; end
				if (ph == 4'd7) begin val = {8'h00, hdata}; return K_BYTE; end
			end
			ACT_SEN_RD: begin
				if (ph == 4'd1) begin val = {8'h00, rg}; return K_BYTE; end
				if (ph == 4'd2) begin val = cfg.sensor_read_addr_wait; return K_WAIT; end
				if (ph == 4'd3) begin val = 16'h00ff; return K_BYTE; end
				if (ph == 4'd4) begin val = cfg.sensor_read_hold; return K_WAIT; end
			end
			ACT_SEN_WR: begin
				if (ph == 4'd1) begin val = {8'h00, rg | 8'h80}; return K_BYTE; end
				if (ph == 4'd2) begin val = cfg.sensor_write_addr_wait; return K_WAIT; end
				if (ph == 4'd3) begin val = {8'h00, hdata}; return K_BYTE; end
				if (ph == 4'd4) begin val = cfg.sensor_write_hold; return K_WAIT; end
			end
			default: ;
		endcase
		return K_FINISH;
	endfunction

	function automatic void goto_phase(logic [3:0] p);
		logic [15:0] v;
		step_kind_t  k;
		ph = p;
		k  = phase_step(v);
		if (k == K_BYTE) begin
			shreg = v[7:0];
			nbits = '0;
			half  = 1'b0;
		end else if (k == K_WAIT) begin
			wcnt = v;
		end
	endfunction

	// one half SCLK period; returns 1 when a read finishes here
	function automatic logic clock_half(logic sdi);
		logic [15:0] v;
		step_kind_t  k;
		for (int g = 0; g < 3; g++) begin
			k = phase_step(v);
			case (k)
				K_BYTE: begin
					if (!half) begin
						pins[PIN_SCLK] = 1'b0;
						pins[PIN_MOSI] = shreg[7];
						half = 1'b1;
					end else begin
						pins[PIN_SCLK] = 1'b1;
						shreg = {shreg[6:0], sdi};
						nbits = nbits + 4'd1;
						half  = 1'b0;
						if (nbits >= BITS_PER_BYTE) goto_phase(ph + 4'd1);
					end
					return 1'b0;
				end
				K_WAIT: begin
					if (wcnt != 0) begin
						wcnt = wcnt - 16'd1;
						return 1'b0;
					end
					// expired wait: the next step runs on this same tick
					goto_phase(ph + 4'd1);
				end
				K_DESEL: begin
					pins[PIN_EE]   = 1'b1;
					pins[PIN_MOSI] = 1'b1;
					pins[PIN_SCLK] = 1'b1;
					goto_phase(ph + 4'd1);
					return 1'b0;
				end
				K_SEL: begin
					pins[PIN_EE] = 1'b0;
					goto_phase(ph + 4'd1);
					return 1'b0;
				end
				default: begin
					pins = PINS_IDLE;
					ph   = PHASE_IDLE;
					return (cur == ACT_EE_RD) || (cur == ACT_SEN_RD);
				end
			endcase
		end
		return 1'b0;
	endfunction

	function automatic result_t step_link(logic [2:0] act, logic [8:0] adr, logic [7:0] dat,
			logic sdi);
		result_t r;
		r = '0;
		if (act == ACT_TICK) begin
			if (ph != PHASE_IDLE && clock_half(sdi)) begin
				r.read_valid = 1'b1;
				r.read_byte  = shreg;
			end
		end else if (act <= ACT_SEN_WR) begin
			if (ph != PHASE_IDLE) begin
				r.rejected = 1'b1;
			end else begin
				cur   = act;
				haddr = adr;
				hdata = dat;
				pins  = (act <= ACT_EE_WR) ? PINS_EE_SEL : PINS_SEN_SEL;
				goto_phase(PHASE_FIRST);
			end
		end
		r.sclk            = pins[PIN_SCLK];
		r.mosi            = pins[PIN_MOSI];
		r.eeprom_select_n = pins[PIN_EE];
		r.sensor_select_n = pins[PIN_SEN];
		r.busy_res        = (ph != PHASE_IDLE);
		return r;
	endfunction

	function automatic void load_reg(logic [2:0] idx, logic [15:0] val);
		case (idx)
			REG_READ_OPCODE:    cfg.read_opcode            = val[7:0];
			REG_WRITE_OPCODE:   cfg.write_opcode           = val[7:0];
			REG_WREN_OPCODE:    cfg.write_enable_opcode    = val[7:0];
			REG_ENABLE_GAP:     cfg.enable_gap_ticks       = val;
			REG_SEN_RD_ADDR_WT: cfg.sensor_read_addr_wait  = val;
			REG_SEN_RD_HOLD:    cfg.sensor_read_hold       = val;
			REG_SEN_WR_ADDR_WT: cfg.sensor_write_addr_wait = val;
			REG_SEN_WR_HOLD:    cfg.sensor_write_hold      = val;
			default: ;
		endcase
	endfunction

	function automatic void show(string tag, result_t r);
		$display("  %s: sclk=%0b mosi=%0b ee_n=%0b sen_n=%0b busy=%0b rv=%0b rb=%02h rej=%0b",
			tag, r.sclk, r.mosi, r.eeprom_select_n, r.sensor_select_n, r.busy_res,
			r.read_valid, r.read_byte, r.rejected);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			clear_link();
			due_states.delete();
			bad = 0;
			errors    <= 0;
			pending   <= 0;
			link_busy <= 1'b0;
		end else begin
			// compare before forecasting: a word taken now cannot be out yet
			if (pop && !empty) begin
				got = {sclk, mosi, eeprom_select_n, sensor_select_n, busy_res, read_valid,
					read_byte, rejected};
				if (due_states.size() == 0) begin
					bad++;
					if (bad <= SHOW_LIMIT) begin
						$display("%0t: result word with nothing outstanding", $realtime);
						show("got", got);
					end
				end else begin
					want = due_states.pop_front();
					if (got !== want) begin
						bad++;
						if (bad <= SHOW_LIMIT) begin
							$display("%0t: result word mismatch", $realtime);
							show("expected", want);
							show("actual  ", got);
						end
					end
				end
			end
			if (cfg_valid && cfg_ready) load_reg(cfg_index, cfg_data);
			if (push && !full) due_states.push_back(step_link(action, address, wr_data, miso));
			errors    <= bad;
			pending   <= due_states.size();
			link_busy <= (ph != PHASE_IDLE);
		end
	end

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the SPI EEPROM/sensor master: directed transactions at the
// reset settings, then randomized transactions under random register
// settings, with rejected commands, no-ops and random flow control.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import spism_pkg::*;

	localparam logic [2:0] ACT_NOP_LO   = 3'd5;
	localparam logic [2:0] ACT_NOP_HI   = 3'd7;
	localparam int         ITEM_COUNT   = 1050;
	localparam int         CYCLE_LIMIT  = 3000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [2:0]  action = ACT_TICK;
	logic [8:0]  address = '0;
	logic [7:0]  wr_data = '0;
	logic        miso = 1'b0;
	logic        empty;
	logic        pop = 1'b0;
	logic        sclk;
	logic        mosi;
	logic        eeprom_select_n;
	logic        sensor_select_n;
	logic        busy_res;
	logic        read_valid;
	logic [7:0]  read_byte;
	logic        rejected;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = REG_READ_OPCODE;
	logic [15:0] cfg_data = '0;

	int          errors;
	int          pending;
	logic        link_busy;
	int          words = 0;
	bit          hurry = 1'b0;
	int unsigned cycles = 0;

	spi_eeprom_and_sensor_master u_dut (.*);
	spi_link_checker u_chk (.*);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(13, 60);
	endfunction

	function automatic logic [15:0] pick_wait();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return $urandom_range(0, 3);
		if (r < 90) return $urandom_range(4, 20);
		return $urandom_range(21, 120);
	endfunction

	initial begin : result_pacing
		int n;
		@(posedge clk);
		forever begin
			n = hurry ? 0 : pick_gap();
			if (n > 0) begin
				pop <= 1'b0;
				repeat (n) @(posedge clk);
			end
			pop <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	end

	task automatic send_word(input logic [2:0] act, input logic [8:0] adr,
			input logic [7:0] dat, input logic sdi);
		int gap;
		gap = hurry ? 0 : pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push       <= 1'b1;
		action     <= act;
		address    <= adr;
		wr_data    <= dat;
		miso       <= sdi;
		do @(posedge clk); while (full);
		words++;
	endtask

	task automatic send_tick();
		send_word(ACT_TICK, 9'($urandom), 8'($urandom), 1'($urandom));
	endtask

	// a command that lands mid-transaction, or an unused action code
	task automatic send_noise();
		if ($urandom_range(0, 1) == 0)
			send_word(3'($urandom_range(ACT_EE_RD, ACT_SEN_WR)), 9'($urandom), 8'($urandom),
				1'($urandom));
		else
			send_word(3'($urandom_range(ACT_NOP_LO, ACT_NOP_HI)), 9'($urandom), 8'($urandom),
				1'($urandom));
	endtask

	// issue one command and clock it until the sequencer is back to idle
	task automatic run_cmd(input logic [2:0] act, input logic [8:0] adr, input logic [7:0] dat,
			input int noise_pct);
		send_word(act, adr, dat, 1'($urandom));
		do begin
			if ($urandom_range(0, 99) < noise_pct) send_noise();
			else send_tick();
		end while (link_busy);
	endtask

	// drop push, drain all results and finish any transaction still open
	task automatic settle();
		forever begin
			push <= 1'b0;
			do @(posedge clk); while (pending != 0);
			if (!link_busy) break;
			send_tick();
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_regs(input logic [7:0] rd_op, input logic [7:0] wr_op,
			input logic [7:0] wren_op, input logic [15:0] gap, input logic [15:0] rd_wait,
			input logic [15:0] rd_hold, input logic [15:0] wr_wait, input logic [15:0] wr_hold);
		logic [15:0] junk;
		settle();
		junk = $urandom;
		// upper bits of the byte registers must be dropped
		write_reg(REG_READ_OPCODE, {junk[15:8], rd_op});
		write_reg(REG_WRITE_OPCODE, {junk[7:0], wr_op});
		write_reg(REG_WREN_OPCODE, {~junk[15:8], wren_op});
		write_reg(REG_ENABLE_GAP, gap);
		write_reg(REG_SEN_RD_ADDR_WT, rd_wait);
		write_reg(REG_SEN_RD_HOLD, rd_hold);
		write_reg(REG_SEN_WR_ADDR_WT, wr_wait);
		write_reg(REG_SEN_WR_HOLD, wr_hold);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_all_kinds(input int noise_pct);
		run_cmd(ACT_EE_RD, 9'h1ff, 8'h00, noise_pct);
		run_cmd(ACT_EE_WR, 9'h000, 8'hff, noise_pct);
		run_cmd(ACT_SEN_RD, 9'h1ff, 8'h5a, noise_pct);
		run_cmd(ACT_SEN_WR, 9'h080, 8'h00, noise_pct);
	endtask

	initial begin : stimulus
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// idle ticks, unused action codes and one of each command at reset settings
		send_tick();
		for (int a = ACT_NOP_LO; a <= ACT_NOP_HI; a++)
			send_word(3'(a), 9'h1ff, 8'hff, 1'b1);
		run_all_kinds(0);

		// all-ones opcodes with address bit 8 merged, short waits
		set_regs(8'hff, 8'hff, 8'hff, pick_wait(), pick_wait(), pick_wait(), pick_wait(),
			pick_wait());

		while (words < ITEM_COUNT) begin
			if ($urandom_range(0, 3) == 0)
				set_regs(8'($urandom), 8'($urandom), 8'($urandom), pick_wait(), pick_wait(),
					pick_wait(), pick_wait(), pick_wait());
			hurry = ($urandom_range(0, 4) == 0);
			case ($urandom_range(0, 9))
				0: send_tick();
				1: send_noise();
				default: run_cmd(3'($urandom_range(ACT_EE_RD, ACT_SEN_WR)), 9'($urandom),
					8'($urandom), 4);
			endcase
		end
		hurry = 1'b0;

		settle();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
